@@ rtl/chain_link_angle_constrained_follow_assert.svh @@
// assertion macros for the chain link follower
`ifndef CHAIN_LINK_ANGLE_CONSTRAINED_FOLLOW_ASSERT_SVH
`define CHAIN_LINK_ANGLE_CONSTRAINED_FOLLOW_ASSERT_SVH

// whenever a holds, b holds on the same edge
`define CCF_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("ccf assertion failed");

// whenever a holds, b holds on the next edge
`define CCF_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("ccf assertion failed");

`endif

@@ rtl/ccf_pkg.sv @@
// shared types, constants and helpers of the chain link follower
package ccf_pkg;

  localparam int CordicIters = 16;
  localparam int CordicW     = 36;
  localparam int TrigW       = 19;
  localparam int PaddrW      = 4;

  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_POINTER = 2'd1;
  localparam logic [1:0] OP_PARENT  = 2'd2;

  localparam logic [1:0] REG_LINK_RADIUS   = 2'd0;
  localparam logic [1:0] REG_PAIR_COUNT    = 2'd1;
  localparam logic [1:0] REG_MAX_DEVIATION = 2'd2;

  localparam logic [21:0] LINK_RADIUS_RST   = 22'd2560;
  localparam logic [4:0]  PAIR_COUNT_RST    = 5'd4;
  localparam logic [14:0] MAX_DEVIATION_RST = 15'd1365;

  localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;
  localparam logic signed [15:0] HALF_TURN    = -16'sd32768;
  localparam logic signed [CordicW-1:0] CORDIC_X0 = CordicW'(39797);

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [15:0] parent_angle;
    logic [21:0]        parent_spacing;
  } in_t;

  typedef struct packed {
    logic [3:0]         pair_index;
    logic signed [23:0] plus_side_x;
    logic signed [23:0] plus_side_y;
    logic signed [23:0] minus_side_x;
    logic signed [23:0] minus_side_y;
    logic signed [23:0] new_center_x;
    logic signed [23:0] new_center_y;
    logic signed [15:0] new_heading;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ATAN, ST_HEAD, ST_HSTART, ST_HSC, ST_HMUL, ST_HUPD,
    ST_PAIR, ST_DIV, ST_PSC, ST_PMUL, ST_PSAVE, ST_MSC, ST_MMUL, ST_MSAVE, ST_OUT
  } state_e;

  typedef enum logic [1:0] {ANG_HEAD, ANG_PLUS, ANG_MINUS} ang_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     cordic_start;
    logic     cordic_vec;
    ang_sel_e ang_sel;
    logic     set_heading;
    logic     mul_en;
    logic     mul_radius;
    logic     upd_center;
    logic     div_start;
    logic     store_plus;
    logic     store_minus;
    logic     out_load;
    logic     pair_inc;
  } cmd_t;

  typedef struct packed {
    logic in_parent;
    logic cordic_done;
    logic div_done;
    logic pair_last;
  } sts_t;

  function automatic logic signed [15:0] ang_tab(input logic [3:0] idx);
    logic signed [15:0] v;
    case (idx)
      4'd0:    v = 16'sd8192;
      4'd1:    v = 16'sd4836;
      4'd2:    v = 16'sd2555;
      4'd3:    v = 16'sd1297;
      4'd4:    v = 16'sd651;
      4'd5:    v = 16'sd326;
      4'd6:    v = 16'sd163;
      4'd7:    v = 16'sd81;
      4'd8:    v = 16'sd41;
      4'd9:    v = 16'sd20;
      4'd10:   v = 16'sd10;
      4'd11:   v = 16'sd5;
      4'd12:   v = 16'sd3;
      4'd13:   v = 16'sd1;
      4'd14:   v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -27'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ccf_cordic.sv @@
// shared cordic unit, vectoring for atan2 and rotation for sine and cosine
module ccf_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             vec_i,
  input  logic signed [24:0]               dx_i,
  input  logic signed [24:0]               dy_i,
  input  logic signed [15:0]               angle_i,
  output logic                             done_o,
  output logic signed [ccf_pkg::TrigW-1:0] cos_o,
  output logic signed [ccf_pkg::TrigW-1:0] sin_o,
  output logic signed [15:0]               z_o
);
  import ccf_pkg::*;

  logic signed [CordicW-1:0] x_q, y_q, xs, ys, xi, yi, xn, yn;
  logic signed [15:0]        z_q, zi;
  logic [3:0]                it_q;
  logic                      busy_q, done_q, vec_q, neg_q, negi, up;

  assign xi = CordicW'($signed({dx_i, 8'd0}));
  assign yi = CordicW'($signed({dy_i, 8'd0}));

  always_comb begin
    zi   = angle_i;
    negi = 1'b0;
    if (angle_i > QUARTER_TURN) begin
      zi   = angle_i + HALF_TURN;
      negi = 1'b1;
    end else if (angle_i < -QUARTER_TURN) begin
      zi   = angle_i - HALF_TURN;
      negi = 1'b1;
    end
  end

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  // up: rotate clockwise and add the table angle
  assign up = vec_q ? (y_q > 0) : (z_q < 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
      vec_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
        vec_q  <= vec_i;
        neg_q  <= vec_i ? 1'b0 : negi;
      end else if (busy_q) begin
        it_q <= it_q + 4'd1;
        if (it_q == 4'(CordicIters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (vec_i) begin
        x_q <= (xi < 0) ? -xi : xi;
        y_q <= (xi < 0) ? -yi : yi;
        z_q <= (xi < 0) ? HALF_TURN : 16'sd0;
      end else begin
        x_q <= CORDIC_X0;
        y_q <= '0;
        z_q <= zi;
      end
    end else if (busy_q) begin
      if (up) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang_tab(it_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang_tab(it_q);
      end
    end
  end

  assign xn     = neg_q ? -x_q : x_q;
  assign yn     = neg_q ? -y_q : y_q;
  assign cos_o  = xn[TrigW-1:0];
  assign sin_o  = yn[TrigW-1:0];
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

@@ rtl/ccf_dp.sv @@
// datapath: link state, heading clamp, rim offset divider, scaling and word register
module ccf_dp #(
  parameter int MAX_PAIRS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ccf_pkg::in_t    in_i,
  input  logic [21:0]     link_radius_i,
  input  logic [4:0]      pair_count_i,
  input  logic [14:0]     max_deviation_i,
  input  ccf_pkg::cmd_t   cmd_i,
  output ccf_pkg::sts_t   sts_o,
  output ccf_pkg::out_t   out_o
);
  import ccf_pkg::*;

  localparam int PW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int NW    = $clog2(MAX_PAIRS + 1);
  localparam int NUMW  = NW + 14;
  localparam int DCW   = $clog2(NUMW + 1);

  logic signed [23:0] tx_q, ty_q, cx_q, cy_q;
  logic signed [15:0] pa_q, hd_q, hd_d;
  logic [21:0]        sp_q;
  logic [PW-1:0]      pair_q;
  logic [NW-1:0]      n_q, n_d, k;
  logic signed [24:0] dx, dy;
  logic               coincide;

  // rim offset divider
  logic [NUMW-1:0]    num_q, quo_q;
  logic [NW-1:0]      rem_q;
  logic [NW:0]        rem_sh;
  logic               qbit;
  logic [DCW-1:0]     dcnt_q;
  logic               ddone_q;
  logic signed [15:0] off;

  // cordic and scaling
  logic signed [15:0]       angle, cz, want, dd;
  logic signed [16:0]       d17, md17, dc;
  logic signed [TrigW-1:0]  ccos, csin;
  logic                     cdone;
  logic signed [22:0]       len;
  logic signed [41:0]       prod_x_q, prod_y_q, rnd_x, rnd_y;
  logic signed [25:0]       scx, scy;
  logic signed [23:0]       px_q, py_q, mx_q, my_q;
  out_t                     out_q;

  assign dx       = 25'(tx_q) - 25'(cx_q);
  assign dy       = 25'(ty_q) - 25'(cy_q);
  assign coincide = (dx == '0) && (dy == '0);

  always_comb begin
    n_d = NW'(pair_count_i);
    if (pair_count_i == 5'd0) begin
      n_d = NW'(1);
    end else if (32'(pair_count_i) > MAX_PAIRS) begin
      n_d = NW'(MAX_PAIRS);
    end
  end

  // heading: parent angle plus wrapped and clamped offset
  always_comb begin
    want = coincide ? 16'sd0 : cz;
    dd   = want - pa_q;
    d17  = 17'(dd);
    md17 = $signed({2'b00, max_deviation_i});
    if (d17 > md17) begin
      dc = md17;
    end else if (d17 < -md17) begin
      dc = -md17;
    end else begin
      dc = d17;
    end
    hd_d = pa_q + dc[15:0];
  end

  assign k      = n_q - NW'(1) - NW'(pair_q);
  assign rem_sh = {rem_q, num_q[NUMW-1]};
  assign qbit   = (rem_sh >= {1'b0, n_q});
  assign off    = $signed({2'b00, quo_q[13:0]});

  always_comb begin
    case (cmd_i.ang_sel)
      ANG_PLUS:  angle = hd_q + QUARTER_TURN - off;
      ANG_MINUS: angle = hd_q - QUARTER_TURN + off;
      default:   angle = hd_q;
    endcase
  end

  ccf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .vec_i   (cmd_i.cordic_vec),
    .dx_i    (dx),
    .dy_i    (dy),
    .angle_i (angle),
    .done_o  (cdone),
    .cos_o   (ccos),
    .sin_o   (csin),
    .z_o     (cz)
  );

  assign len   = cmd_i.mul_radius ? $signed({1'b0, link_radius_i}) : $signed({1'b0, sp_q});
  assign rnd_x = (prod_x_q + 42'sd32768) >>> 16;
  assign rnd_y = (prod_y_q + 42'sd32768) >>> 16;
  assign scx   = rnd_x[25:0];
  assign scy   = rnd_y[25:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      hd_q    <= '0;
      pair_q  <= '0;
      n_q     <= NW'(1);
      dcnt_q  <= '0;
      ddone_q <= 1'b0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.load_in) begin
        pair_q <= '0;
        n_q    <= n_d;
        if (in_i.operation == OP_POINTER) begin
          cx_q <= in_i.target_x;
          cy_q <= in_i.target_y;
        end
      end
      if (cmd_i.set_heading) begin
        hd_q <= hd_d;
      end
      if (cmd_i.upd_center) begin
        cx_q <= sat24(27'(tx_q) - 27'(scx));
        cy_q <= sat24(27'(ty_q) - 27'(scy));
      end
      if (cmd_i.pair_inc) begin
        pair_q <= pair_q + PW'(1);
      end
      if (cmd_i.div_start) begin
        dcnt_q <= DCW'(NUMW);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tx_q <= in_i.target_x;
      ty_q <= in_i.target_y;
      pa_q <= in_i.parent_angle;
      sp_q <= in_i.parent_spacing;
    end
    if (cmd_i.div_start) begin
      num_q <= {k, 14'd0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (dcnt_q != '0) begin
      num_q <= {num_q[NUMW-2:0], 1'b0};
      quo_q <= {quo_q[NUMW-2:0], qbit};
      rem_q <= qbit ? NW'(rem_sh - {1'b0, n_q}) : rem_sh[NW-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_x_q <= len * ccos;
      prod_y_q <= len * csin;
    end
    if (cmd_i.store_plus) begin
      px_q <= sat24(27'(cx_q) + 27'(scx));
      py_q <= sat24(27'(cy_q) + 27'(scy));
    end
    if (cmd_i.store_minus) begin
      mx_q <= sat24(27'(cx_q) + 27'(scx));
      my_q <= sat24(27'(cy_q) + 27'(scy));
    end
    if (cmd_i.out_load) begin
      out_q.pair_index   <= 4'(pair_q);
      out_q.plus_side_x  <= px_q;
      out_q.plus_side_y  <= py_q;
      out_q.minus_side_x <= mx_q;
      out_q.minus_side_y <= my_q;
      out_q.new_center_x <= cx_q;
      out_q.new_center_y <= cy_q;
      out_q.new_heading  <= hd_q;
      out_q.last         <= sts_o.pair_last;
    end
  end

  assign sts_o.in_parent   = (in_i.operation == OP_PARENT);
  assign sts_o.cordic_done = cdone;
  assign sts_o.div_done    = ddone_q;
  assign sts_o.pair_last   = (NW'(pair_q) == n_q - NW'(1));
  assign out_o             = out_q;

endmodule

@@ rtl/ccf_ctrl.sv @@
// sequencer for one step: heading update on a parent follow, then one word per rim pair
module ccf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ccf_pkg::sts_t sts_i,
  output ccf_pkg::cmd_t cmd_o
);
  import ccf_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_free;
  logic   atan_go_q;

  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = sts_i.in_parent ? ST_ATAN : ST_PAIR;
        end
      end
      ST_ATAN: begin
        // cordic reads the freshly loaded target in the cycle after accept
        cmd_o.cordic_start = atan_go_q;
        cmd_o.cordic_vec   = atan_go_q;
        if (!sts_i.cordic_done) begin
          state_d = ST_ATAN;
        end
      end
      ST_HEAD: begin
        cmd_o.set_heading = 1'b1;
        state_d = ST_HSTART;
      end
      ST_HSTART: begin
        cmd_o.cordic_start = 1'b1;
        cmd_o.ang_sel = ANG_HEAD;
        state_d = ST_HSC;
      end
      ST_HSC: begin
        if (sts_i.cordic_done) begin
          state_d = ST_HMUL;
        end
      end
      ST_HMUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_HUPD;
      end
      ST_HUPD: begin
        cmd_o.upd_center = 1'b1;
        state_d = ST_PAIR;
      end
      ST_PAIR: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.cordic_start = 1'b1;
          cmd_o.ang_sel = ANG_PLUS;
          state_d = ST_PSC;
        end
      end
      ST_PSC: begin
        if (sts_i.cordic_done) begin
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_radius = 1'b1;
        state_d = ST_PSAVE;
      end
      ST_PSAVE: begin
        cmd_o.store_plus = 1'b1;
        cmd_o.cordic_start = 1'b1;
        cmd_o.ang_sel = ANG_MINUS;
        state_d = ST_MSC;
      end
      ST_MSC: begin
        if (sts_i.cordic_done) begin
          state_d = ST_MMUL;
        end
      end
      ST_MMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_radius = 1'b1;
        state_d = ST_MSAVE;
      end
      ST_MSAVE: begin
        cmd_o.store_minus = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.pair_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.pair_inc = 1'b1;
            state_d = ST_PAIR;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // atan2 kicks off right after the item is captured
    if (state_q == ST_IDLE && in_valid_i && sts_i.in_parent) begin
      state_d = ST_ATAN;
    end
    if (state_q == ST_ATAN && sts_i.cordic_done) begin
      state_d = ST_HEAD;
    end
  end

  // vectoring run starts on the cycle after capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atan_go_q <= 1'b0;
    end else begin
      atan_go_q <= (state_q == ST_IDLE) && in_valid_i && sts_i.in_parent;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ rtl/chain_link_angle_constrained_follow.sv @@
// top level of the angle constrained chain link follower
// One chain link. Each input word holds the link, jumps its centre to a pointer, or
// follows a parent link: the heading becomes the parent angle plus the clamped
// offset toward the target, and the centre is pulled to parent_spacing behind the
// target. Every step then yields one output word per rim point pair (pair_count,
// clamped to 1..MAX_PAIRS), with last set on the final pair. Items are taken one
// at a time; a new item may be accepted while the final word still waits in the
// output register. A parent follow runs one 16-step vectoring cordic, one 16-step
// rotation cordic and a multiply; each rim pair runs a one bit per cycle offset
// divider of 14 + ceil(log2(MAX_PAIRS+1)) steps and two rotation passes of the one
// shared cordic. Output stalls hold the sequence. Configuration is an apb slave:
// link_radius at 0x0, pair_count at 0x4, max_deviation at 0x8. The user must see that
// they are written only while the block is idle; the block itself does not enforce it.
`include "chain_link_angle_constrained_follow_assert.svh"

module chain_link_angle_constrained_follow #(
  parameter int MAX_PAIRS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ccf_pkg::in_t                 in_i,
  // rim pair words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ccf_pkg::out_t                out_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccf_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ccf_pkg::*;

  logic [21:0] link_radius_q;
  logic [4:0]  pair_count_q;
  logic [14:0] max_deviation_q;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  // apb register file, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_radius_q   <= LINK_RADIUS_RST;
      pair_count_q    <= PAIR_COUNT_RST;
      max_deviation_q <= MAX_DEVIATION_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LINK_RADIUS:   link_radius_q   <= pwdata[21:0];
        REG_PAIR_COUNT:    pair_count_q    <= pwdata[4:0];
        REG_MAX_DEVIATION: max_deviation_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LINK_RADIUS:   prdata = 32'(link_radius_q);
      REG_PAIR_COUNT:    prdata = 32'(pair_count_q);
      REG_MAX_DEVIATION: prdata = 32'(max_deviation_q);
      default:           prdata = '0;
    endcase
  end

  // sequencer: owns handshakes and the output valid bit
  ccf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: link state, cordic, divider, output word register
  ccf_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .link_radius_i   (link_radius_q),
    .pair_count_i    (pair_count_q),
    .max_deviation_i (max_deviation_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_o           (out_o)
  );

  // the block is busy right after taking a word
  `CCF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a new word is never loaded over one still waiting
  `CCF_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !out_valid_o || out_ready_i)
  // cordic needs its iterations before reporting done
  `CCF_ASSERT_NEXT(a_cordic_latency, clk_i, rst_ni, cmd.cordic_start, !sts.cordic_done)

endmodule

@@ sim/tb_top.sv @@
// testbench for the angle constrained chain link follower
`timescale 1ns / 100ps

module tb_top;
  import ccf_pkg::*;

  localparam int MaxPairs   = 16;
  localparam int CycleLimit = 1500000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chain_link_angle_constrained_follow #(.MAX_PAIRS(MaxPairs)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state and its copy of the registers
  logic signed [23:0] link_cx, link_cy;
  logic [15:0]        link_hd;
  logic [21:0]        cfg_radius;
  logic [4:0]         cfg_pairs;
  logic [14:0]        cfg_maxdev;

  out_t   pending_pairs[$];
  int     mismatches;
  int     pairs_seen;
  int     words_sent;
  longint cycles;
  bit     rx_stall_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle counter doubles as the watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [15:0] ang_step(input int i);
    case (i)
      0: return 16'd8192;   1: return 16'd4836;  2: return 16'd2555;
      3: return 16'd1297;   4: return 16'd651;   5: return 16'd326;
      6: return 16'd163;    7: return 16'd81;    8: return 16'd41;
      9: return 16'd20;     10: return 16'd10;   11: return 16'd5;
      12: return 16'd3;     13: return 16'd1;    14: return 16'd1;
      default: return 16'd0;
    endcase
  endfunction

  // vectoring pass, inputs scaled by 256, left half plane flipped first
  function automatic logic [15:0] heading_toward(input longint dx, input longint dy);
    longint x, y, xs, ys;
    int z;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += int'(ang_step(i));
      end else begin
        x = x - ys; y = y + xs; z -= int'(ang_step(i));
      end
    end
    return z[15:0];
  endfunction

  // rotation pass, results in q16
  task automatic unit_vector(input logic [15:0] a, output longint c, output longint s);
    int z;
    bit flip;
    longint x, y, xs, ys;
    z = int'($signed(a));
    flip = 1'b0;
    x = 39797;
    y = 0;
    if (z > 16384) begin
      z -= 32768; flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= int'(ang_step(i));
      end else begin
        x = x + ys; y = y - xs; z += int'(ang_step(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint scaled(input longint len, input longint trig);
    return (len * trig + 32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // advance the link by one word and queue the rim pairs it yields
  task automatic predict_link(input in_t w);
    longint dx, dy, d, c, s, cp, sp, cm, sm;
    logic [15:0] want, ap, am;
    int n, off;
    out_t r;
    if (w.operation == OP_POINTER) begin
      link_cx = w.target_x;
      link_cy = w.target_y;
    end else if (w.operation == OP_PARENT) begin
      dx = longint'(w.target_x) - longint'(link_cx);
      dy = longint'(w.target_y) - longint'(link_cy);
      want = (dx == 0 && dy == 0) ? 16'd0 : heading_toward(dx, dy);
      d = longint'($signed(want - w.parent_angle));
      if (d > longint'(cfg_maxdev)) d = longint'(cfg_maxdev);
      if (d < -longint'(cfg_maxdev)) d = -longint'(cfg_maxdev);
      link_hd = w.parent_angle + d[15:0];
      unit_vector(link_hd, c, s);
      link_cx = clip24(longint'(w.target_x) - scaled(longint'(w.parent_spacing), c));
      link_cy = clip24(longint'(w.target_y) - scaled(longint'(w.parent_spacing), s));
    end
    n = int'(cfg_pairs);
    if (n < 1) n = 1;
    if (n > MaxPairs) n = MaxPairs;
    for (int i = 0; i < n; i++) begin
      off = (16384 * (n - 1 - i)) / n;
      ap = link_hd + 16'd16384 - off[15:0];
      am = link_hd - 16'd16384 + off[15:0];
      unit_vector(ap, cp, sp);
      unit_vector(am, cm, sm);
      r.pair_index   = i[3:0];
      r.plus_side_x  = clip24(longint'(link_cx) + scaled(longint'(cfg_radius), cp));
      r.plus_side_y  = clip24(longint'(link_cy) + scaled(longint'(cfg_radius), sp));
      r.minus_side_x = clip24(longint'(link_cx) + scaled(longint'(cfg_radius), cm));
      r.minus_side_y = clip24(longint'(link_cy) + scaled(longint'(cfg_radius), sm));
      r.new_center_x = link_cx;
      r.new_center_y = link_cy;
      r.new_heading  = link_hd;
      r.last         = (i == n - 1);
      pending_pairs = {pending_pairs, r};
    end
  endtask

  // drive one word, predicting at the accepting edge
  task automatic send_word(input in_t w);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_link(w);
    words_sent++;
  endtask

  // rim pair checker, ready stalls drawn per word
  initial begin : pair_checker
    int gap;
    out_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = rx_stall_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rim pair word %p", out_o);
      end else begin
        want = pending_pairs.pop_front();
        pairs_seen++;
        if (out_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("pair mismatch\n  exp %p\n  got %p", want, out_o);
        end
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PaddrW'({idx, 2'b00}); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LINK_RADIUS:   cfg_radius = v[21:0];
      REG_PAIR_COUNT:    cfg_pairs  = v[4:0];
      REG_MAX_DEVIATION: cfg_maxdev = v[14:0];
      default: ;
    endcase
  endtask

  // drop valid, wait for every queued pair, then let the block settle
  task automatic drain_pairs();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic configure(input logic [21:0] rad, input logic [4:0] np, input logic [14:0] md);
    drain_pairs();
    reg_write(REG_LINK_RADIUS, 32'(rad));
    reg_write(REG_PAIR_COUNT, 32'(np));
    reg_write(REG_MAX_DEVIATION, 32'(md));
  endtask

  function automatic in_t make_word(input logic [1:0] op, input int x, input int y,
                                    input int pa, input int sp);
    in_t w;
    w.operation = op;
    w.target_x = x[23:0];
    w.target_y = y[23:0];
    w.parent_angle = pa[15:0];
    w.parent_spacing = sp[21:0];
    return w;
  endfunction

  function automatic in_t random_word();
    in_t w;
    int pick;
    w = in_t'(88'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 9);
    // mostly parent follows, mostly near coordinates and short spacing
    if (pick < 7) w.operation = OP_PARENT;
    else if (pick < 9) w.operation = OP_POINTER;
    else w.operation = $urandom_range(0, 1) ? OP_HOLD : 2'd3;
    if ($urandom_range(0, 3) != 0) begin
      w.target_x = 24'($signed(link_cx) + $signed(25'($urandom_range(0, 16383)) - 25'sd8192));
      w.target_y = 24'($signed(link_cy) + $signed(25'($urandom_range(0, 16383)) - 25'sd8192));
      w.parent_spacing = 22'($urandom_range(0, 8191));
    end
    return w;
  endfunction

  task automatic test_directed_extremes();
    send_word(make_word(OP_PARENT, 0, 0, 0, 2560));            // target on centre
    send_word(make_word(OP_POINTER, 8388607, 8388607, 0, 0));
    send_word(make_word(OP_PARENT, -8388608, -8388608, 32767, 4194303));
    send_word(make_word(OP_POINTER, -8388608, 8388607, 0, 0));
    send_word(make_word(OP_PARENT, 8388607, -8388608, -32768, 4194303));
    send_word(make_word(OP_HOLD, 123, 456, 789, 1000));
    send_word(make_word(2'd3, -1, -1, -1, 4194303));            // unused code holds
    send_word(make_word(OP_POINTER, 0, 0, 0, 0));
    // offset of exactly half a turn: target straight ahead, parent at half turn
    send_word(make_word(OP_PARENT, 4096, 0, -32768, 1024));
    send_word(make_word(OP_POINTER, 0, 0, 0, 0));
    send_word(make_word(OP_PARENT, -4096, 0, 0, 1024));
    send_word(make_word(OP_PARENT, 0, 4096, 16384, 0));
    send_word(make_word(OP_PARENT, 0, -4096, -16384, 512));
  endtask

  task automatic test_register_corners();
    configure(22'd0, 5'd1, 15'd0);
    send_word(make_word(OP_PARENT, 3000, -2000, 100, 700));
    send_word(make_word(OP_PARENT, -3000, 2000, -100, 700));
    configure(22'h3fffff, 5'd16, 15'd16384);
    send_word(make_word(OP_PARENT, 5000, 5000, 32767, 300));
    send_word(make_word(OP_POINTER, 0, 0, 0, 0));
    configure(22'd1000, 5'd0, 15'h7fff);                         // count below range
    send_word(make_word(OP_PARENT, -5000, 100, 0, 300));
    configure(22'd1000, 5'd31, 15'd16384);                       // count above range
    send_word(make_word(OP_HOLD, 0, 0, 0, 0));
    configure(22'd2560, 5'd3, 15'd1365);
  endtask

  task automatic test_random_chain(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 90 == 89)
        configure(22'($urandom_range(0, 20000)), 5'($urandom_range(1, 5)),
                  15'($urandom_range(0, 16384)));
      rx_stall_on = (k % 60) < 45;
      send_word(random_word());
    end
    rx_stall_on = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    link_cx = '0; link_cy = '0; link_hd = '0;
    cfg_radius = LINK_RADIUS_RST;
    cfg_pairs  = PAIR_COUNT_RST;
    cfg_maxdev = MAX_DEVIATION_RST;
    mismatches = 0; pairs_seen = 0; words_sent = 0; cycles = 0;
    rx_stall_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_register_corners();
    test_random_chain(355);

    drain_pairs();
    $display("sent %0d words covering hold, pointer and parent follows", words_sent);
    $display("checked %0d rim pair words across register extremes", pairs_seen);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d pairs missing", mismatches, pending_pairs.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
